// ===== rtl/kvt_pkg.sv =====
package kvt_pkg;

	localparam int WORD_W = 32;

	typedef logic [1:0] func_t;
	typedef logic [1:0] status_t;
	typedef logic signed [WORD_W-1:0] word_t;

	localparam func_t FUNC_LOOKUP = 2'd0;
	localparam func_t FUNC_DELETE = 2'd1;
	localparam func_t FUNC_SET    = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;

	localparam word_t MISS_WORD = '1;

	// command token handed from cell to cell
	typedef struct packed {
		logic  valid;
		func_t func;
		word_t key;
		word_t value;
		logic  found;
		logic  claimed;
		word_t rdata;
	} token_t;

	// resolution sent to every cell when the token leaves the chain
	typedef struct packed {
		logic commit;
		logic drop;
	} bcast_t;

endpackage

// ===== rtl/kvt_cmd_if.sv =====
interface kvt_cmd_if;
	import kvt_pkg::*;

	logic  valid;
	logic  ready;
	func_t func;
	word_t key;
	word_t new_value;

	modport source (output valid, output func, output key, output new_value, input ready);
	modport sink (input valid, input func, input key, input new_value, output ready);
endinterface

// ===== rtl/kvt_rsp_if.sv =====
interface kvt_rsp_if;
	import kvt_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	word_t   result_word;

	modport source (output valid, output status, output result_word, input ready);
	modport sink (input valid, input status, input result_word, output ready);
endinterface

// ===== rtl/key_value_table.sv =====
// Key/value table: ENTRIES slots of unique signed 32-bit keys with 32-bit values.
// cmd channel (valid/ready): func (lookup, delete, set), key, new_value.
// rsp channel (valid/ready): status and result_word, exactly one word per command.
// Each slot is a cell in a chain; a command travels down the chain one cell per
// cycle, through the head register, every cell, then the holding and output
// registers before its response word is offered. Only one command is in the
// chain at a time, so a new command is not taken while one walks the chain.
// A set of a new key tentatively claims the lowest free cell on the way
// and the claim is committed or dropped when the command leaves the chain.
// cmd.ready falls on acceptance and rises again once the response has moved to
// the output register, so a new command may be taken while the previous
// response still waits. If the receiver stalls, the finished response waits in
// a holding register and no further command is accepted until it moves on.
// Reset empties the table at once (all slots invalid); no clearing pass.
module key_value_table #(
	parameter int ENTRIES = 64
) (
	input logic     clk,
	input logic     arst_n,
	kvt_cmd_if.sink   cmd,
	kvt_rsp_if.source rsp
);
	import kvt_pkg::*;

	token_t  chain [ENTRIES+1];
	token_t  head_s1;
	logic    head_vld_s1;
	bcast_t  bcast;
	token_t  tail;
	logic    busy_q;
	logic    accept;
	logic    move;
	status_t res_status;
	word_t   res_word;
	logic    hold_vld_q;
	status_t hold_status_q;
	word_t   hold_word_q;
	logic    out_vld_q;
	status_t out_status_q;
	word_t   out_word_q;

	assign cmd.ready = !busy_q;
	assign accept    = cmd.valid && !busy_q;

	always_comb begin
		chain[0]       = head_s1;
		chain[0].valid = head_vld_s1;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kvt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (chain[i]),
			.bcast  (bcast),
			.tok_out(chain[i+1])
		);
	end

	assign tail         = chain[ENTRIES];
	assign bcast.commit = tail.valid && (tail.func == FUNC_SET) && !tail.found && tail.claimed;
	assign bcast.drop   = tail.valid;

	always_comb begin
		res_status = ST_NOT_FOUND;
		res_word   = MISS_WORD;
		case (tail.func)
			FUNC_LOOKUP, FUNC_DELETE: begin
				if (tail.found) begin
					res_status = ST_OK;
					res_word   = tail.rdata;
				end
			end
			FUNC_SET: begin
				if (tail.found || tail.claimed) begin
					res_status = ST_OK;
					res_word   = tail.key;
				end else begin
					res_status = ST_FULL;
				end
			end
			default: begin
				res_status = ST_NOT_FOUND;
				res_word   = MISS_WORD;
			end
		endcase
	end

	assign move = hold_vld_q && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			head_vld_s1 <= 1'b0;
			hold_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			head_vld_s1 <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (tail.valid) begin
				hold_vld_q <= 1'b1;
			end else if (move) begin
				hold_vld_q <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_s1.valid   <= 1'b1;
			head_s1.func    <= cmd.func;
			head_s1.key     <= cmd.key;
			head_s1.value   <= cmd.new_value;
			head_s1.found   <= 1'b0;
			head_s1.claimed <= 1'b0;
			head_s1.rdata   <= MISS_WORD;
		end
		if (tail.valid) begin
			hold_status_q <= res_status;
			hold_word_q   <= res_word;
		end
		if (move) begin
			out_status_q <= hold_status_q;
			out_word_q   <= hold_word_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.result_word = out_word_q;

endmodule

// ===== rtl/kvt_cell.sv =====
module kvt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  kvt_pkg::token_t tok_in,
	input  kvt_pkg::bcast_t bcast,
	output kvt_pkg::token_t tok_out
);
	import kvt_pkg::*;

	word_t  key_q;
	word_t  value_q;
	logic   valid_q;
	logic   pending_q;
	logic   hit;
	logic   claim;
	token_t nxt;
	token_t pay_s1;
	logic   vld_s1;

	assign hit   = tok_in.valid && valid_q && (key_q == tok_in.key);
	// first free slot seen by a set takes the key tentatively
	assign claim = tok_in.valid && (tok_in.func == FUNC_SET) && !valid_q && !tok_in.claimed;

	always_comb begin
		nxt         = tok_in;
		nxt.found   = tok_in.found | hit;
		nxt.claimed = tok_in.claimed | claim;
		if (hit) begin
			nxt.rdata = value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			pending_q <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= tok_in.valid;
			if (hit && (tok_in.func == FUNC_DELETE)) begin
				valid_q <= 1'b0;
			end else if (bcast.commit && pending_q) begin
				valid_q <= 1'b1;
			end
			if (claim) begin
				pending_q <= 1'b1;
			end else if (bcast.commit || bcast.drop) begin
				pending_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pay_s1 <= nxt;
		if (claim) begin
			key_q <= tok_in.key;
		end
		if (claim || (hit && (tok_in.func == FUNC_SET))) begin
			value_q <= tok_in.value;
		end
	end

	always_comb begin
		tok_out       = pay_s1;
		tok_out.valid = vld_s1;
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import kvt_pkg::*;

	localparam int TABLE_SLOTS = 64;
	localparam func_t FUNC_UNKNOWN = 2'd3;
	localparam word_t WORD_MIN = 32'h8000_0000;
	localparam word_t WORD_MAX = 32'h7fff_ffff;
	localparam int BATCH_LEN = 50;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} batch_mode_t;

	typedef struct packed {
		status_t status;
		word_t   word;
	} reply_t;

	// shadow copy of the table plus the replies it has promised
	class table_shadow;
		word_t  slot_key[TABLE_SLOTS];
		word_t  slot_value[TABLE_SLOTS];
		bit     slot_used[TABLE_SLOTS];
		reply_t pending[$];
		int     errors;
		int     n_found;
		int     n_absent;
		int     n_full;

		function void note_command(func_t f, word_t k, word_t v);
			int hit;
			int free;
			reply_t r;
			hit = -1;
			free = -1;
			r.status = ST_NOT_FOUND;
			r.word = MISS_WORD;
			for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
				if (slot_used[i] && slot_key[i] == k)
					hit = i;
				if (!slot_used[i])
					free = i;
			end
			case (f)
				FUNC_LOOKUP: begin
					if (hit >= 0) begin
						r.status = ST_OK;
						r.word = slot_value[hit];
					end
				end
				FUNC_DELETE: begin
					if (hit >= 0) begin
						r.status = ST_OK;
						r.word = slot_value[hit];
						slot_used[hit] = 1'b0;
					end
				end
				FUNC_SET: begin
					if (hit >= 0) begin
						slot_value[hit] = v;
						r.status = ST_OK;
						r.word = k;
					end else if (free >= 0) begin
						slot_key[free] = k;
						slot_value[free] = v;
						slot_used[free] = 1'b1;
						r.status = ST_OK;
						r.word = k;
					end else begin
						r.status = ST_FULL;
					end
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		function void check_response(status_t s, word_t w);
			reply_t exp_reply;
			if (pending.size() == 0) begin
				$display("%0t: response word with nothing expected: status %0d word %0d",
					$time, s, w);
				errors++;
				return;
			end
			exp_reply = pending.pop_front();
			if (s !== exp_reply.status) begin
				$display("%0t: status mismatch, expected %0d got %0d",
					$time, exp_reply.status, s);
				errors++;
			end
			if (w !== exp_reply.word) begin
				$display("%0t: result_word mismatch, expected %0d got %0d",
					$time, exp_reply.word, w);
				errors++;
			end
			case (exp_reply.status)
				ST_OK:        n_found++;
				ST_NOT_FOUND: n_absent++;
				default:      n_full++;
			endcase
		endfunction

		// random key currently held in the table, if any
		function bit pick_stored_key(output word_t k);
			int start;
			int idx;
			start = $urandom_range(0, TABLE_SLOTS - 1);
			k = '0;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				idx = (start + i) % TABLE_SLOTS;
				if (slot_used[idx]) begin
					k = slot_key[idx];
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	table_shadow sb;

	kvt_cmd_if cmd();
	kvt_rsp_if rsp();

	key_value_table #(
		.ENTRIES(TABLE_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly short gaps, a few long ones that span a whole walk of the chain
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(50, 150);
	endfunction

	function automatic word_t random_word();
		if ($urandom_range(0, 99) < 15) begin
			case ($urandom_range(0, 5))
				0: return WORD_MIN;
				1: return WORD_MAX;
				2: return '0;
				3: return '1;
				4: return 32'sd1;
				default: return -32'sd2;
			endcase
		end
		return $urandom();
	endfunction

	task automatic issue(func_t f, word_t k, word_t v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.func <= f;
		cmd.key <= k;
		cmd.new_value <= v;
		do @(posedge clk); while (!cmd.ready);
		sb.note_command(f, k, v);
	endtask

	task automatic run_batch(batch_mode_t mode);
		int r;
		word_t k;
		word_t stored;
		bit have;
		for (int n = 0; n < BATCH_LEN; n++) begin
			r = $urandom_range(0, 99);
			have = sb.pick_stored_key(stored);
			k = have ? stored : random_word();
			case (mode)
				MODE_FILL: begin
					if (r < 80)
						issue(FUNC_SET, random_word(), random_word());
					else if (r < 90)
						issue(FUNC_SET, k, random_word());
					else
						issue(FUNC_LOOKUP, k, random_word());
				end
				MODE_DRAIN: begin
					if (r < 70)
						issue(FUNC_DELETE, k, random_word());
					else if (r < 80)
						issue(FUNC_DELETE, random_word(), random_word());
					else if (r < 90)
						issue(FUNC_LOOKUP, random_word(), random_word());
					else
						issue(FUNC_SET, random_word(), random_word());
				end
				default: begin
					if ($urandom_range(0, 99) >= 60)
						k = random_word();
					if (r < 30)
						issue(FUNC_LOOKUP, k, random_word());
					else if (r < 55)
						issue(FUNC_DELETE, k, random_word());
					else if (r < 95)
						issue(FUNC_SET, k, random_word());
					else
						issue(FUNC_UNKNOWN, k, random_word());
				end
			endcase
		end
	endtask

	// response side: random back-pressure, checked at every accepted word
	initial begin
		automatic int stall = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
				sb.check_response(rsp.status, rsp.result_word);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				stall--;
			end else begin
				rsp.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin
		#10ms;
		$display("key_value_table test failed");
		$finish;
	end

	initial begin
		automatic int waited = 0;
		batch_mode_t plan[6];
		sb = new;
		plan = '{MODE_FILL, MODE_FILL, MODE_MIXED, MODE_DRAIN, MODE_DRAIN, MODE_MIXED};
		calm = 1'b1;
		arst_n <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.func <= FUNC_LOOKUP;
		cmd.key <= '0;
		cmd.new_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unknown command, extremes, update in place, delete twice
		issue(FUNC_LOOKUP, '0, '0);
		issue(FUNC_DELETE, '0, WORD_MAX);
		issue(FUNC_UNKNOWN, 32'sd5, '1);
		issue(FUNC_SET, WORD_MIN, WORD_MAX);
		issue(FUNC_SET, WORD_MAX, WORD_MIN);
		issue(FUNC_SET, '0, '0);
		issue(FUNC_SET, '1, 32'h1234_5678);
		issue(FUNC_LOOKUP, WORD_MIN, '0);
		issue(FUNC_LOOKUP, WORD_MAX, '0);
		issue(FUNC_LOOKUP, '1, '0);
		issue(FUNC_LOOKUP, 32'h7fff_fffe, '0);
		issue(FUNC_SET, WORD_MIN, 32'h8000_0001);
		issue(FUNC_LOOKUP, WORD_MIN, '0);
		issue(FUNC_UNKNOWN, WORD_MIN, '0);
		issue(FUNC_LOOKUP, WORD_MIN, '0);
		issue(FUNC_DELETE, WORD_MAX, '0);
		issue(FUNC_DELETE, WORD_MAX, '0);
		issue(FUNC_LOOKUP, WORD_MAX, '0);
		issue(FUNC_SET, 32'sd1, '1);
		issue(FUNC_LOOKUP, 32'sd1, '0);
		issue(FUNC_DELETE, '0, '0);
		issue(FUNC_DELETE, '1, '0);
		issue(FUNC_DELETE, WORD_MIN, '0);
		issue(FUNC_DELETE, 32'sd1, '0);

		// two rounds of fill to overflow, mix, drain, mix
		for (int b = 0; b < 12; b++) begin
			calm = ($urandom_range(0, 4) == 0);
			run_batch(plan[b % 6]);
		end
		calm = 1'b0;
		cmd.valid <= 1'b0;

		while (sb.pending.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (TABLE_SLOTS + 20) @(posedge clk);

		if (sb.pending.size() != 0) begin
			$display("%0t: %0d response words never arrived", $time, sb.pending.size());
			sb.errors++;
		end
		$display("Checked %0d response words: %0d hits or stores, %0d misses, %0d refusals on a full table",
			sb.n_found + sb.n_absent + sb.n_full, sb.n_found, sb.n_absent, sb.n_full);
		if (sb.errors == 0)
			$display("key_value_table test passed");
		else
			$display("key_value_table test failed");
		$finish;
	end

endmodule
